// ----- design/correspondence_tuple_test_top_assert.svh -----
// Assertion macros for the correspondence tuple test block.
`ifndef CORRESPONDENCE_TUPLE_TEST_TOP_ASSERT_SVH
`define CORRESPONDENCE_TUPLE_TEST_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CTT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CTT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ctt_pkg.sv -----
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared constants, codes and control structs of the correspondence tuple
// test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

  // field widths fixed by the interface
  localparam int unsigned IDX_BITS     = 10;
  localparam int unsigned SCALE_BITS   = 16;
  localparam int unsigned CNT_BITS     = 16;
  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS = 1;

  // parameter defaults
  localparam int unsigned STORE_DEPTH_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF  = 20;

  // slot reduction: reciprocal scaling and max depth width
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned DEPTH_BITS  = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_SQ   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_TUPLES = 1'b1;

  localparam logic [SCALE_BITS-1:0] SCALE_SQ_RESET   = 16'd59146;
  localparam logic [CNT_BITS-1:0]   MAX_TUPLES_RESET = 16'd1000;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_TRIAL = 1'b1;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } slot_ctl_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

  typedef struct packed {
    logic diff_en;
    logic sq_en;
    logic sum_en;
    logic prod_en;
    logic cmp_en;
  } edge_ctl_t;

  typedef struct packed {
    logic out_en;
    logic cnt_en;
  } count_ctl_t;

endpackage

`default_nettype wire

// ----- design/ctt_slot.sv -----
// ----------------------------------------------------------------------------
// ctt_slot
// Input register and index reduction modulo the store depth, two stages:
// reciprocal multiply for the quotient, then subtract with one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_slot
  import ctt_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  wire                               clk_i,
  input  slot_ctl_t                         ctl_i,
  input  wire                               action_i,
  input  wire  [IDX_BITS-1:0]               load_index_i,
  input  wire  [IDX_BITS-1:0]               first_index_i,
  input  wire  [IDX_BITS-1:0]               second_index_i,
  input  wire  [IDX_BITS-1:0]               third_index_i,
  input  wire  [5:0][COORD_BITS-1:0]        pt_i,
  output logic                              action_o,
  output logic [2:0][$clog2(STORE_DEPTH)-1:0] slot_o,
  output logic [5:0][COORD_BITS-1:0]        pt_o
);

  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned RSH   = RECIP_SHIFT;
  localparam int unsigned PW    = IDX_BITS + RSH;
  localparam int unsigned MW    = IDX_BITS + DEPTH_BITS;
  localparam logic [RSH-1:0] RECIP   = RSH'((64'd1 << RSH) / STORE_DEPTH);
  localparam logic [MW-1:0]  DEPTH_M = MW'(STORE_DEPTH);

  logic [2:0][IDX_BITS-1:0] v_d, v_q;
  logic [2:0][IDX_BITS-1:0] quo_d, quo_q;
  logic [2:0][PW-1:0]       prod;
  logic [2:0][MW-1:0]       qd, rem, fix;
  logic [2:0][AW-1:0]       slot_d, slot_q;
  logic                     act1_q, act2_q;
  logic [5:0][COORD_BITS-1:0] pt1_q, pt2_q;

  // stage 1: quotient estimate, low by at most one
  always_comb begin
    v_d[0] = (action_i == ACT_LOAD) ? load_index_i : first_index_i;
    v_d[1] = second_index_i;
    v_d[2] = third_index_i;
    for (int k = 0; k < 3; k++) begin
      prod[k]  = PW'(v_d[k]) * PW'(RECIP);
      quo_d[k] = prod[k][RSH +: IDX_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.s1_en) begin
      v_q    <= v_d;
      quo_q  <= quo_d;
      act1_q <= action_i;
      pt1_q  <= pt_i;
    end
  end

  // stage 2: remainder, one compare-subtract
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qd[k]     = MW'(quo_q[k]) * DEPTH_M;
      rem[k]    = MW'(v_q[k]) - qd[k];
      fix[k]    = (rem[k] >= DEPTH_M) ? (rem[k] - DEPTH_M) : rem[k];
      slot_d[k] = fix[k][AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.s2_en) begin
      slot_q <= slot_d;
      act2_q <= act1_q;
      pt2_q  <= pt1_q;
    end
  end

  assign action_o = act2_q;
  assign slot_o   = slot_q;
  assign pt_o     = pt2_q;

endmodule

`default_nettype wire

// ----- design/ctt_store.sv -----
// ----------------------------------------------------------------------------
// ctt_store
// Correspondence store, three copies written together so that one trial
// reads its three entries at once. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_store
  import ctt_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  wire                                 clk_i,
  input  store_ctl_t                          ctl_i,
  input  wire  [$clog2(STORE_DEPTH)-1:0]      wr_addr_i,
  input  wire  [5:0][COORD_BITS-1:0]          wr_data_i,
  input  wire  [2:0][$clog2(STORE_DEPTH)-1:0] rd_addr_i,
  output logic [2:0][5:0][COORD_BITS-1:0]     rd_data_o
);

  localparam int unsigned EW = 6 * COORD_BITS;

  for (genvar c = 0; c < 3; c++) begin : g_copy
    logic [EW-1:0] mem [STORE_DEPTH];
    logic [EW-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (ctl_i.wr_en) begin
        mem[wr_addr_i] <= wr_data_i;
      end
      if (ctl_i.rd_en) begin
        rd_q <= mem[rd_addr_i[c]];
      end
    end

    assign rd_data_o[c] = rd_q;
  end

endmodule

`default_nettype wire

// ----- design/ctt_edge.sv -----
// ----------------------------------------------------------------------------
// ctt_edge
// One triangle edge: source and target squared lengths and the two strict
// scale bounds. Five stages: |diff|, square, sum, scale product, compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_edge
  import ctt_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire                        clk_i,
  input  edge_ctl_t                  ctl_i,
  input  wire  [SCALE_BITS-1:0]      scale_sq_i,
  input  wire  [5:0][COORD_BITS-1:0] pa_i,
  input  wire  [5:0][COORD_BITS-1:0] pb_i,
  output logic                       ok_o
);

  localparam int unsigned DW   = COORD_BITS + 1;
  localparam int unsigned SQW  = 2 * DW;
  localparam int unsigned SUMW = SQW + 2;
  localparam int unsigned PW   = SUMW + SCALE_BITS;

  logic [5:0][DW-1:0]  diff, mag_d, mag_q;
  logic [5:0][SQW-1:0] sq_q;
  logic [SUMW-1:0]     ls2_q, lt2_q, ls2_dly_q, lt2_dly_q;
  logic [PW-1:0]       ls_prod_q, lt_prod_q;
  logic                ok_d, ok_q;

  // entries 0..2 source axes, 3..5 target axes
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      diff[k]  = {pa_i[k][COORD_BITS-1], pa_i[k]} - {pb_i[k][COORD_BITS-1], pb_i[k]};
      mag_d[k] = diff[k][DW-1] ? (~diff[k] + DW'(1)) : diff[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.diff_en) begin
      mag_q <= mag_d;
    end
    if (ctl_i.sq_en) begin
      for (int k = 0; k < 6; k++) begin
        sq_q[k] <= SQW'(mag_q[k]) * SQW'(mag_q[k]);
      end
    end
    if (ctl_i.sum_en) begin
      ls2_q <= SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
      lt2_q <= SUMW'(sq_q[3]) + SUMW'(sq_q[4]) + SUMW'(sq_q[5]);
    end
    if (ctl_i.prod_en) begin
      ls_prod_q <= PW'(ls2_q) * PW'(scale_sq_i);
      lt_prod_q <= PW'(lt2_q) * PW'(scale_sq_i);
      ls2_dly_q <= ls2_q;
      lt2_dly_q <= lt2_q;
    end
    if (ctl_i.cmp_en) begin
      ok_q <= ok_d;
    end
  end

  // strict on both sides: a product equal to its bound does not pass
  assign ok_d = (ls_prod_q < {lt2_dly_q, SCALE_BITS'(0)}) &&
                (lt_prod_q < {ls2_dly_q, SCALE_BITS'(0)});

  assign ok_o = ok_q;

endmodule

`default_nettype wire

// ----- design/ctt_count.sv -----
// ----------------------------------------------------------------------------
// ctt_count
// Accepted-tuple counter, limit check and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_count
  import ctt_pkg::*;
(
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  count_ctl_t                ctl_i,
  input  wire  [2:0]                edge_ok_i,
  input  wire  [CNT_BITS-1:0]       max_tuples_i,
  input  wire  [2:0][IDX_BITS-1:0]  idx_i,
  output logic                      accepted_o,
  output logic [IDX_BITS-1:0]       out_first_o,
  output logic [IDX_BITS-1:0]       out_second_o,
  output logic [IDX_BITS-1:0]       out_third_o,
  output logic [CNT_BITS-1:0]       accepted_count_o,
  output logic                      limit_reached_o
);

  logic                      ok_all;
  logic [CNT_BITS-1:0]       cnt_d, cnt_q;
  logic                      acc_q, lim_q;
  logic [CNT_BITS-1:0]       cnt_out_q;
  logic [2:0][IDX_BITS-1:0]  idx_q;

  // count < max <= 0xFFFF, so the increment never wraps
  assign ok_all = (&edge_ok_i) && (cnt_q < max_tuples_i);
  assign cnt_d  = ok_all ? (cnt_q + CNT_BITS'(1)) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.cnt_en) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_en) begin
      acc_q     <= ok_all;
      cnt_out_q <= cnt_d;
      lim_q     <= (cnt_d >= max_tuples_i);
      idx_q     <= idx_i;
    end
  end

  assign accepted_o       = acc_q;
  assign accepted_count_o = cnt_out_q;
  assign limit_reached_o  = lim_q;
  assign out_first_o      = idx_q[0];
  assign out_second_o     = idx_q[1];
  assign out_third_o      = idx_q[2];

endmodule

`default_nettype wire

// ----- design/correspondence_tuple_test_top.sv -----
// Throughput: one item per cycle while out_stall_i is low; loads write the
// store and give no result. Trials pass through all stages in order.
// The only feedback is the tuple counter, settled within the output stage.
// Reset clears stage valids and the counter and loads both config defaults.
// The store is not cleared; an entry must be loaded before a trial reads it.
// ----------------------------------------------------------------------------
// correspondence_tuple_test_top
// Nine-stage pipeline: input/quotient, slot, store read, edge stages, output.
// ----------------------------------------------------------------------------
`default_nettype none

module correspondence_tuple_test_top
  import ctt_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire  [CFG_BITS-1:0]          cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          action_i,
  input  wire  [IDX_BITS-1:0]          load_index_i,
  input  wire  signed [COORD_BITS-1:0] src_x_i,
  input  wire  signed [COORD_BITS-1:0] src_y_i,
  input  wire  signed [COORD_BITS-1:0] src_z_i,
  input  wire  signed [COORD_BITS-1:0] tar_x_i,
  input  wire  signed [COORD_BITS-1:0] tar_y_i,
  input  wire  signed [COORD_BITS-1:0] tar_z_i,
  input  wire  [IDX_BITS-1:0]          first_index_i,
  input  wire  [IDX_BITS-1:0]          second_index_i,
  input  wire  [IDX_BITS-1:0]          third_index_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         accepted_o,
  output logic [IDX_BITS-1:0]          out_first_o,
  output logic [IDX_BITS-1:0]          out_second_o,
  output logic [IDX_BITS-1:0]          out_third_o,
  output logic [CNT_BITS-1:0]          accepted_count_o,
  output logic                         limit_reached_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  // stage numbers
  localparam int unsigned S_IN   = 1;
  localparam int unsigned S_SLOT = 2;
  localparam int unsigned S_RD   = 3;
  localparam int unsigned S_DIFF = 4;
  localparam int unsigned S_SQ   = 5;
  localparam int unsigned S_SUM  = 6;
  localparam int unsigned S_PROD = 7;
  localparam int unsigned S_CMP  = 8;
  localparam int unsigned S_OUT  = 9;

  logic [SCALE_BITS-1:0] scale_sq_q;
  logic [CNT_BITS-1:0]   max_tuples_q;

  logic [S_OUT:S_IN]   valid_d, valid_q;
  logic [S_OUT+1:S_IN] ready;

  logic [5:0][COORD_BITS-1:0]     pt_in, pt_s2;
  logic                           act_s2;
  logic [2:0][AW-1:0]             slot_s2;
  logic [2:0][5:0][COORD_BITS-1:0] rd_s3;
  logic [2:0]                     edge_ok;
  logic [S_CMP:S_IN][2:0][IDX_BITS-1:0] echo_q;

  slot_ctl_t  slot_ctl;
  store_ctl_t store_ctl;
  edge_ctl_t  edge_ctl;
  count_ctl_t count_ctl;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_sq_q   <= SCALE_SQ_RESET;
      max_tuples_q <= MAX_TUPLES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCALE_SQ:   scale_sq_q   <= cfg_data_i;
        CFG_MAX_TUPLES: max_tuples_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // stage handshake: a stage loads when it is empty or its content moves on
  always_comb begin
    ready[S_OUT+1] = !out_stall_i;
    for (int k = S_OUT; k >= S_IN; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    valid_d[S_IN] = in_valid_i;
    for (int k = S_SLOT; k <= S_OUT; k++) begin
      valid_d[k] = valid_q[k-1];
    end
    // loads retire at the store write
    valid_d[S_RD] = valid_q[S_SLOT] && (act_s2 == ACT_TRIAL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = S_IN; k <= S_OUT; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  assign in_stall_o  = !ready[S_IN];
  assign out_valid_o = valid_q[S_OUT];

  // echoed indices ride along
  always_ff @(posedge clk_i) begin
    if (ready[S_IN]) begin
      echo_q[S_IN] <= {third_index_i, second_index_i, first_index_i};
    end
    for (int k = S_SLOT; k <= S_CMP; k++) begin
      if (ready[k]) begin
        echo_q[k] <= echo_q[k-1];
      end
    end
  end

  assign slot_ctl.s1_en    = ready[S_IN];
  assign slot_ctl.s2_en    = ready[S_SLOT];
  assign store_ctl.wr_en   = valid_q[S_SLOT] && (act_s2 == ACT_LOAD) && ready[S_RD];
  assign store_ctl.rd_en   = ready[S_RD];
  assign edge_ctl.diff_en  = ready[S_DIFF];
  assign edge_ctl.sq_en    = ready[S_SQ];
  assign edge_ctl.sum_en   = ready[S_SUM];
  assign edge_ctl.prod_en  = ready[S_PROD];
  assign edge_ctl.cmp_en   = ready[S_CMP];
  assign count_ctl.out_en  = ready[S_OUT];
  assign count_ctl.cnt_en  = valid_q[S_CMP] && ready[S_OUT];

  assign pt_in[0] = src_x_i;
  assign pt_in[1] = src_y_i;
  assign pt_in[2] = src_z_i;
  assign pt_in[3] = tar_x_i;
  assign pt_in[4] = tar_y_i;
  assign pt_in[5] = tar_z_i;

  ctt_slot #(
    .STORE_DEPTH (STORE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_slot (
    .clk_i          (clk_i),
    .ctl_i          (slot_ctl),
    .action_i       (action_i),
    .load_index_i   (load_index_i),
    .first_index_i  (first_index_i),
    .second_index_i (second_index_i),
    .third_index_i  (third_index_i),
    .pt_i           (pt_in),
    .action_o       (act_s2),
    .slot_o         (slot_s2),
    .pt_o           (pt_s2)
  );

  ctt_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (store_ctl),
    .wr_addr_i (slot_s2[0]),
    .wr_data_i (pt_s2),
    .rd_addr_i (slot_s2),
    .rd_data_o (rd_s3)
  );

  for (genvar e = 0; e < 3; e++) begin : g_edge
    ctt_edge #(
      .COORD_BITS (COORD_BITS)
    ) u_edge (
      .clk_i      (clk_i),
      .ctl_i      (edge_ctl),
      .scale_sq_i (scale_sq_q),
      .pa_i       (rd_s3[e]),
      .pb_i       (rd_s3[(e + 1) % 3]),
      .ok_o       (edge_ok[e])
    );
  end

  ctt_count u_count (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (count_ctl),
    .edge_ok_i        (edge_ok),
    .max_tuples_i     (max_tuples_q),
    .idx_i            (echo_q[S_CMP]),
    .accepted_o       (accepted_o),
    .out_first_o      (out_first_o),
    .out_second_o     (out_second_o),
    .out_third_o      (out_third_o),
    .accepted_count_o (accepted_count_o),
    .limit_reached_o  (limit_reached_o)
  );

endmodule

`default_nettype wire

// ----- design/ctt_checker.sv -----
// ----------------------------------------------------------------------------
// ctt_checker
// Port-level checks of the tuple test block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "correspondence_tuple_test_top_assert.svh"

module ctt_checker
  import ctt_pkg::*;
(
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_stall_i,
  input wire                    out_valid_i,
  input wire                    out_stall_i,
  input wire                    accepted_i,
  input wire [IDX_BITS-1:0]     out_first_i,
  input wire [CNT_BITS-1:0]     accepted_count_i,
  input wire                    limit_reached_i,
  input wire                    cfg_we_i,
  input wire [CFG_IDX_BITS-1:0] cfg_index_i,
  input wire [CFG_BITS-1:0]     cfg_data_i
);

  logic [CNT_BITS-1:0] max_q;
  logic [CNT_BITS-1:0] last_cnt_q;

  // shadow of the limit register and of the last delivered count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q      <= MAX_TUPLES_RESET;
      last_cnt_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_MAX_TUPLES)) begin
        max_q <= cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        last_cnt_q <= accepted_count_i;
      end
    end
  end

  `CTT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(accepted_count_i) && $stable(out_first_i), "stalled result changed")
  `CTT_ASSERT_IMPLY(a_cnt_step, clk_i, rst_ni, out_valid_i, accepted_count_i == (last_cnt_q + CNT_BITS'(accepted_i)), "count does not follow accepted trials")
  `CTT_ASSERT_IMPLY(a_limit_flag, clk_i, rst_ni, out_valid_i, limit_reached_i == (accepted_count_i >= max_q), "limit flag disagrees with count")
  `CTT_ASSERT_IMPLY(a_no_stall_empty, clk_i, rst_ni, !out_valid_i, !in_stall_i, "input stalled with empty output")

endmodule

bind correspondence_tuple_test_top ctt_checker u_ctt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_i       (in_stall_o),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .accepted_i       (accepted_o),
  .out_first_i      (out_first_o),
  .accepted_count_i (accepted_count_o),
  .limit_reached_i  (limit_reached_o),
  .cfg_we_i         (cfg_we_i),
  .cfg_index_i      (cfg_index_i),
  .cfg_data_i       (cfg_data_i)
);

`default_nettype wire
